// ===== hdl/sts_pkg.sv =====
// Shared types, codes and widths for the sorted tab stop toggle set.
package sts_pkg;

  localparam int OP_W     = 2;
  localparam int POS_W    = 12;
  localparam int GRID_W   = 12;
  localparam int RULER_W  = 13;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;
  localparam int COUNT_W  = 7;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam int DEF_MAX_TABS = 64;
  localparam int DEF_POS_BITS = 12;

  localparam logic [GRID_W-1:0]  GRID_RESET  = 12'd8;
  localparam logic [RULER_W-1:0] RULER_RESET = 13'd4096;

  localparam logic [OP_W-1:0] OP_CLICK = 2'd0;
  localparam logic [OP_W-1:0] OP_PROG  = 2'd1;
  localparam logic [OP_W-1:0] OP_DUMP  = 2'd2;

  localparam logic REG_GRID_STEP   = 1'b0;
  localparam logic REG_RULER_WIDTH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_REMOVED  = 3'd1,
    ST_IGNORED  = 3'd2,
    ST_FULL     = 3'd3,
    ST_ENTRY    = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    RA_ZERO, RA_IDX1, RA_J1, RA_J2, RA_CNT1, RA_JM2
  } raddr_sel_t;

  typedef enum logic {WR_SHIFT, WR_NEW} wsel_t;

  typedef enum logic [1:0] {SL_ZERO, SL_IDX, SL_J} slot_sel_t;

  typedef enum logic [1:0] {VS_ZERO, VS_SNAP, VS_RDATA} val_sel_t;

  typedef struct packed {
    logic       latch_in;
    logic       mod_start;
    logic       snap_ld;
    logic       found_clr;
    logic       found_ld;
    logic       idx_clr;
    logic       idx_inc;
    logic       j_clr;
    logic       j_ld_idx;
    logic       j_ld_count;
    logic       j_inc;
    logic       j_dec;
    logic       rd_en;
    raddr_sel_t ra_sel;
    logic       wr_en;
    wsel_t      wsel;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       out_ld;
    status_t    out_status;
    slot_sel_t  out_slot;
    val_sel_t   out_val;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            out_of_range;
    logic            count_zero;
    logic            full;
    logic            mod_done;
    logic            found;
    logic            rd_lt;
    logic            rd_eq;
    logic            idx1_eq_count;
    logic            idx1_lt_count;
    logic            j1_eq_count;
    logic            j2_lt_count;
    logic            jm1_gt_idx;
    logic            count_gt_idx;
    logic            out_free;
  } stat_t;

endpackage

// ===== hdl/sorted_tab_stop_toggle_set_core.sv =====
// Sorted tab stop toggle set: top level with configuration registers.
//
// Request channel (req_valid/req_stall, operation, position): a click or
// programmed toggle, or a dump of the stored set. Response channel
// (rsp_valid/rsp_stall): status, slot_index, entry_count, entry_value, last.
// One request is worked on at a time; req_stall is high while busy.
// A toggle snaps the position through a bit-serial remainder unit,
// scans the store up to its slot one entry per cycle, then shifts the
// later entries one per cycle. Ignored and empty requests go straight
// from decode to the response step. A dump reads the first entry in
// decode, then gives one response per cycle while rsp_stall is low.
// The response sits in an output register; a new request is taken while
// it waits. While rsp_stall is high the response holds and the engine
// waits before loading the next one.
// Reset (synchronous) empties the set and restores grid_step to 8 and
// ruler_width to 4096. Registers: grid_step at 0x0, ruler_width at 0x4.
module sorted_tab_stop_toggle_set_core #(
  parameter int MAX_TABS = sts_pkg::DEF_MAX_TABS,
  parameter int POS_BITS = sts_pkg::DEF_POS_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sts_pkg::ADDR_W-1:0]    paddr,
  input  logic [sts_pkg::DATA_W-1:0]    pwdata,
  output logic [sts_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [sts_pkg::OP_W-1:0]      operation,
  input  logic [sts_pkg::POS_W-1:0]     position,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [sts_pkg::STATUS_W-1:0]  status,
  output logic [sts_pkg::SLOT_W-1:0]    slot_index,
  output logic [sts_pkg::COUNT_W-1:0]   entry_count,
  output logic [sts_pkg::POS_W-1:0]     entry_value,
  output logic                          last
);
  import sts_pkg::*;

  logic [GRID_W-1:0]  grid_step;
  logic [RULER_W-1:0] ruler_width;
  cmd_t               cmd;
  stat_t              st;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_step   <= GRID_RESET;
      ruler_width <= RULER_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[ADDR_W-1])
        REG_GRID_STEP:   grid_step   <= pwdata[GRID_W-1:0];
        REG_RULER_WIDTH: ruler_width <= pwdata[RULER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1])
      REG_GRID_STEP:   prdata = DATA_W'(grid_step);
      REG_RULER_WIDTH: prdata = DATA_W'(ruler_width);
      default:         prdata = '0;
    endcase
  end

  sts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .st        (st),
    .cmd       (cmd)
  );

  sts_datapath #(
    .MAX_TABS (MAX_TABS),
    .POS_BITS (POS_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .grid_step   (grid_step),
    .ruler_width (ruler_width),
    .operation   (operation),
    .position    (position),
    .cmd         (cmd),
    .st          (st),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .slot_index  (slot_index),
    .entry_count (entry_count),
    .entry_value (entry_value),
    .last        (last)
  );

endmodule

// ===== hdl/sts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sts_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/sts_snap.sv =====
// Iterative remainder unit, one dividend bit per cycle, for grid snapping.
module sts_snap #(
  parameter int DIV_W = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [DIV_W-1:0]          dividend,
  input  logic [sts_pkg::GRID_W-1:0] divisor,
  output logic                      done,
  output logic [sts_pkg::GRID_W-1:0] rem
);
  import sts_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  quo;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [GRID_W:0]   r_sh;

  assign r_sh = {rem, quo[DIV_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W);
        quo  <= dividend;
        rem  <= '0;
      end else if (busy) begin
        quo <= quo << 1;
        cnt <= cnt - CNT_W'(1);
        if (r_sh >= {1'b0, divisor}) begin
          rem <= GRID_W'(r_sh - {1'b0, divisor});
        end else begin
          rem <= r_sh[GRID_W-1:0];
        end
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/sts_datapath.sv =====
// Datapath: tab store, snap unit, search and shift pointers, response register.
module sts_datapath #(
  parameter int MAX_TABS = sts_pkg::DEF_MAX_TABS,
  parameter int POS_BITS = sts_pkg::DEF_POS_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [sts_pkg::GRID_W-1:0]    grid_step,
  input  logic [sts_pkg::RULER_W-1:0]   ruler_width,
  input  logic [sts_pkg::OP_W-1:0]      operation,
  input  logic [sts_pkg::POS_W-1:0]     position,
  input  sts_pkg::cmd_t                 cmd,
  output sts_pkg::stat_t                st,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [sts_pkg::STATUS_W-1:0]  status,
  output logic [sts_pkg::SLOT_W-1:0]    slot_index,
  output logic [sts_pkg::COUNT_W-1:0]   entry_count,
  output logic [sts_pkg::POS_W-1:0]     entry_value,
  output logic                          last
);
  import sts_pkg::*;

  localparam int VW = (POS_BITS < POS_W) ? POS_BITS : POS_W;
  localparam int CW = $clog2(MAX_TABS + 1);
  localparam int IW = $clog2(MAX_TABS);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_TABS);

  logic [OP_W-1:0]   op;
  logic [VW-1:0]     pos;
  logic [VW-1:0]     snapped;
  logic              found;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     j;
  logic [CW-1:0]     count;

  logic [VW-1:0]     rdata;
  logic [VW-1:0]     wdata;
  logic [IW-1:0]     raddr;
  logic [IW-1:0]     waddr;
  logic [GRID_W-1:0] rem;
  logic              mod_done;
  logic [CW:0]       idx_p1;
  logic [CW:0]       j_p1;
  logic [CW:0]       j_p2;
  logic [CW-1:0]     j_m2;
  logic [CW-1:0]     cnt_m1;
  logic              out_free;
  logic [CW-1:0]     slot_mux;
  logic [VW-1:0]     val_mux;

  assign idx_p1   = {1'b0, idx} + (CW+1)'(1);
  assign j_p1     = {1'b0, j} + (CW+1)'(1);
  assign j_p2     = {1'b0, j} + (CW+1)'(2);
  assign j_m2     = j - CW'(2);
  assign cnt_m1   = count - CW'(1);
  assign out_free = !rsp_valid || !rsp_stall;

  always_comb begin
    case (cmd.ra_sel)
      RA_ZERO: raddr = '0;
      RA_IDX1: raddr = idx_p1[IW-1:0];
      RA_J1:   raddr = j_p1[IW-1:0];
      RA_J2:   raddr = j_p2[IW-1:0];
      RA_CNT1: raddr = cnt_m1[IW-1:0];
      RA_JM2:  raddr = j_m2[IW-1:0];
      default: raddr = '0;
    endcase
  end

  assign waddr = (cmd.wsel == WR_NEW) ? idx[IW-1:0] : j[IW-1:0];
  assign wdata = (cmd.wsel == WR_NEW) ? snapped : rdata;

  sts_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_TABS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  sts_snap #(
    .DIV_W (VW)
  ) u_snap (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_start),
    .dividend (pos),
    .divisor  (grid_step),
    .done     (mod_done),
    .rem      (rem)
  );

  always_comb begin
    st               = '0;
    st.op            = op;
    st.out_of_range  = RULER_W'(pos) >= ruler_width;
    st.count_zero    = count == '0;
    st.full          = count >= CNT_MAX;
    st.mod_done      = mod_done;
    st.found         = found;
    st.rd_lt         = rdata < snapped;
    st.rd_eq         = rdata == snapped;
    st.idx1_eq_count = idx_p1 == {1'b0, count};
    st.idx1_lt_count = idx_p1 < {1'b0, count};
    st.j1_eq_count   = j_p1 == {1'b0, count};
    st.j2_lt_count   = j_p2 < {1'b0, count};
    st.jm1_gt_idx    = {1'b0, j} > idx_p1;
    st.count_gt_idx  = count > idx;
    st.out_free      = out_free;
  end

  always_comb begin
    case (cmd.out_slot)
      SL_IDX:  slot_mux = idx;
      SL_J:    slot_mux = j;
      default: slot_mux = '0;
    endcase
    case (cmd.out_val)
      VS_SNAP:  val_mux = snapped;
      VS_RDATA: val_mux = rdata;
      default:  val_mux = '0;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= cnt_m1;
      end
      if (cmd.out_ld) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op  <= operation;
      pos <= position[VW-1:0];
    end
    if (cmd.snap_ld) begin
      snapped <= (grid_step == '0) ? pos : pos - rem[VW-1:0];
    end
    if (cmd.found_clr) begin
      found <= 1'b0;
    end else if (cmd.found_ld) begin
      found <= st.rd_eq;
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx_p1[CW-1:0];
    end
    if (cmd.j_clr) begin
      j <= '0;
    end else if (cmd.j_ld_idx) begin
      j <= idx;
    end else if (cmd.j_ld_count) begin
      j <= count;
    end else if (cmd.j_inc) begin
      j <= j_p1[CW-1:0];
    end else if (cmd.j_dec) begin
      j <= j - CW'(1);
    end
    if (cmd.out_ld) begin
      status      <= cmd.out_status;
      slot_index  <= SLOT_W'(slot_mux);
      entry_count <= COUNT_W'(count);
      entry_value <= POS_W'(val_mux);
      last        <= cmd.out_last;
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX) else $error("tab count above capacity");

  a_no_collide: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_en && cmd.rd_en) |-> (waddr != raddr))
    else $error("shift reads and writes the same slot");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_ld |-> out_free) else $error("response overwritten");

  a_grow: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> (count < CNT_MAX && !found))
    else $error("insert into full set or over a match");

endmodule

// ===== hdl/sts_ctrl.sv =====
// Controller: sequences decode, snap, search, shift and response steps.
module sts_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  sts_pkg::stat_t st,
  output sts_pkg::cmd_t  cmd
);
  import sts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SNAP, S_SRCH0, S_SRCH, S_DECIDE,
    S_DOWN, S_UP, S_INS, S_RESULT, S_DUMP
  } state_t;

  state_t    state, state_next;
  status_t   res_status, res_status_next;
  slot_sel_t res_slot, res_slot_next;
  val_sel_t  res_val, res_val_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd             = '0;
    state_next      = state;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    res_val_next    = res_val;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st.op)
          OP_DUMP: begin
            if (st.count_zero) begin
              res_status_next = ST_EMPTY;
              res_slot_next   = SL_ZERO;
              res_val_next    = VS_ZERO;
              state_next      = S_RESULT;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.ra_sel = RA_ZERO;
              cmd.j_clr  = 1'b1;
              state_next = S_DUMP;
            end
          end
          OP_CLICK: begin
            if (st.out_of_range) begin
              res_status_next = ST_IGNORED;
              res_slot_next   = SL_ZERO;
              res_val_next    = VS_ZERO;
              state_next      = S_RESULT;
            end else begin
              cmd.mod_start = 1'b1;
              state_next    = S_SNAP;
            end
          end
          OP_PROG: begin
            cmd.mod_start = 1'b1;
            state_next    = S_SNAP;
          end
          default: begin
            res_status_next = ST_IGNORED;
            res_slot_next   = SL_ZERO;
            res_val_next    = VS_ZERO;
            state_next      = S_RESULT;
          end
        endcase
      end
      S_SNAP: begin
        if (st.mod_done) begin
          cmd.snap_ld   = 1'b1;
          cmd.found_clr = 1'b1;
          cmd.idx_clr   = 1'b1;
          state_next    = S_SRCH0;
        end
      end
      S_SRCH0: begin
        if (st.count_zero) begin
          state_next = S_DECIDE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.ra_sel = RA_ZERO;
          state_next = S_SRCH;
        end
      end
      S_SRCH: begin
        if (st.rd_lt) begin
          cmd.idx_inc = 1'b1;
          if (st.idx1_eq_count) begin
            state_next = S_DECIDE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.ra_sel = RA_IDX1;
          end
        end else begin
          cmd.found_ld = 1'b1;
          state_next   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (st.found) begin
          if (st.idx1_lt_count) begin
            cmd.j_ld_idx = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.ra_sel   = RA_IDX1;
            state_next   = S_DOWN;
          end else begin
            cmd.cnt_dec     = 1'b1;
            res_status_next = ST_REMOVED;
            res_slot_next   = SL_IDX;
            res_val_next    = VS_SNAP;
            state_next      = S_RESULT;
          end
        end else if (st.full) begin
          res_status_next = ST_FULL;
          res_slot_next   = SL_ZERO;
          res_val_next    = VS_SNAP;
          state_next      = S_RESULT;
        end else if (st.count_gt_idx) begin
          cmd.j_ld_count = 1'b1;
          cmd.rd_en      = 1'b1;
          cmd.ra_sel     = RA_CNT1;
          state_next     = S_UP;
        end else begin
          state_next = S_INS;
        end
      end
      S_DOWN: begin
        cmd.wr_en = 1'b1;
        cmd.wsel  = WR_SHIFT;
        cmd.j_inc = 1'b1;
        if (st.j2_lt_count) begin
          cmd.rd_en  = 1'b1;
          cmd.ra_sel = RA_J2;
        end else begin
          cmd.cnt_dec     = 1'b1;
          res_status_next = ST_REMOVED;
          res_slot_next   = SL_IDX;
          res_val_next    = VS_SNAP;
          state_next      = S_RESULT;
        end
      end
      S_UP: begin
        cmd.wr_en = 1'b1;
        cmd.wsel  = WR_SHIFT;
        cmd.j_dec = 1'b1;
        if (st.jm1_gt_idx) begin
          cmd.rd_en  = 1'b1;
          cmd.ra_sel = RA_JM2;
        end else begin
          state_next = S_INS;
        end
      end
      S_INS: begin
        cmd.wr_en       = 1'b1;
        cmd.wsel        = WR_NEW;
        cmd.cnt_inc     = 1'b1;
        res_status_next = ST_INSERTED;
        res_slot_next   = SL_IDX;
        res_val_next    = VS_SNAP;
        state_next      = S_RESULT;
      end
      S_RESULT: begin
        if (st.out_free) begin
          cmd.out_ld     = 1'b1;
          cmd.out_status = res_status;
          cmd.out_slot   = res_slot;
          cmd.out_val    = res_val;
          cmd.out_last   = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_DUMP: begin
        if (st.out_free) begin
          cmd.out_ld     = 1'b1;
          cmd.out_status = ST_ENTRY;
          cmd.out_slot   = SL_J;
          cmd.out_val    = VS_RDATA;
          cmd.out_last   = st.j1_eq_count;
          cmd.j_inc      = 1'b1;
          if (st.j1_eq_count) begin
            state_next = S_IDLE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.ra_sel = RA_J1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= ST_IGNORED;
      res_slot   <= SL_ZERO;
      res_val    <= VS_ZERO;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
      res_slot   <= res_slot_next;
      res_val    <= res_val_next;
    end
  end

endmodule
